@@ sv/u8v_pkg.sv @@
package u8v_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;

    localparam logic [ByteW-1:0] ByteTerm     = 8'h00;
    localparam logic [ByteW-1:0] ByteCtrlLim  = 8'd32;
    localparam logic [ByteW-1:0] ByteDel      = 8'd127;
    localparam logic [ByteW-1:0] ByteAsciiLim = 8'h80;
    localparam logic [ByteW-1:0] Lead2Lo      = 8'hc2;
    localparam logic [ByteW-1:0] Lead2Hi      = 8'hdf;
    localparam logic [ByteW-1:0] Lead3Lo      = 8'he0;
    localparam logic [ByteW-1:0] Lead3Hi      = 8'hef;
    localparam logic [ByteW-1:0] Lead4Lo      = 8'hf0;
    localparam logic [ByteW-1:0] Lead4Hi      = 8'hf4;

    localparam logic [CpW-1:0] CpMin2    = 21'h00080;
    localparam logic [CpW-1:0] CpMin3    = 21'h00800;
    localparam logic [CpW-1:0] CpMin4    = 21'h10000;
    localparam logic [CpW-1:0] CpMax     = 21'h10ffff;
    localparam logic [CpW-1:0] CpSurrLo  = 21'h0d800;
    localparam logic [CpW-1:0] CpSurrHi  = 21'h0dfff;

    localparam logic [1:0] SeqLen2 = 2'd1;
    localparam logic [1:0] SeqLen3 = 2'd2;
    localparam logic [1:0] SeqLen4 = 2'd3;

    typedef struct packed {
        logic [1:0]     pending;
        logic [1:0]     seq_len;
        logic [CpW-1:0] cp;
        logic           err;
    } t_state;

    localparam t_state StateClear = '{pending: 2'd0, seq_len: 2'd0, cp: '0, err: 1'b0};

    typedef struct packed {
        logic valid;
        logic res;
    } t_verdict;

endpackage

@@ sv/u8v_decode.sv @@
module u8v_decode (
    input  u8v_pkg::t_state              i_state,
    input  logic [u8v_pkg::ByteW-1:0]    i_byte,
    output u8v_pkg::t_state              o_state,
    output u8v_pkg::t_verdict            o_verdict
);
    import u8v_pkg::*;

    logic [CpW-1:0] cp_acc;
    logic [1:0]     pend_dec;
    logic           point_bad;

    always_comb begin
        cp_acc   = {i_state.cp[CpW-7:0], i_byte[5:0]};
        pend_dec = i_state.pending - 2'd1;
        point_bad = ((i_state.seq_len == SeqLen2) && (cp_acc < CpMin2))
                 || ((i_state.seq_len == SeqLen3) && (cp_acc < CpMin3))
                 || ((i_state.seq_len == SeqLen4) && (cp_acc < CpMin4))
                 || (cp_acc > CpMax)
                 || ((cp_acc >= CpSurrLo) && (cp_acc <= CpSurrHi));
    end

    always_comb begin
        o_state   = i_state;
        o_verdict = '{valid: 1'b0, res: 1'b0};
        priority if (i_byte == ByteTerm) begin
            o_verdict = '{valid: 1'b1, res: !i_state.err && (i_state.pending == 2'd0)};
            o_state   = StateClear;
        end else if (i_state.err) begin
            o_state = i_state;
        end else if (i_state.pending != 2'd0) begin
            if (i_byte[7:6] != 2'b10) begin
                o_state.err     = 1'b1;
                o_state.pending = 2'd0;
            end else begin
                o_state.cp      = cp_acc;
                o_state.pending = pend_dec;
                if (pend_dec == 2'd0) begin
                    o_state.err     = point_bad;
                    o_state.cp      = '0;
                    o_state.seq_len = 2'd0;
                end
            end
        end else if (i_byte < ByteAsciiLim) begin
            o_state.err = (i_byte < ByteCtrlLim) || (i_byte == ByteDel);
        end else if ((i_byte >= Lead2Lo) && (i_byte <= Lead2Hi)) begin
            o_state.cp      = CpW'(i_byte[4:0]);
            o_state.pending = 2'd1;
            o_state.seq_len = SeqLen2;
        end else if ((i_byte >= Lead3Lo) && (i_byte <= Lead3Hi)) begin
            o_state.cp      = CpW'(i_byte[3:0]);
            o_state.pending = 2'd2;
            o_state.seq_len = SeqLen3;
        end else if ((i_byte >= Lead4Lo) && (i_byte <= Lead4Hi)) begin
            o_state.cp      = CpW'(i_byte[2:0]);
            o_state.pending = 2'd3;
            o_state.seq_len = SeqLen4;
        end else begin
            o_state.err = 1'b1;
        end
    end

endmodule

@@ sv/utf8_strict_validator_core.sv @@
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+----------------------
// in      | sink      | i_in_valid / o_in_stall   | i_text_byte [7:0]
// out     | source    | o_out_valid / i_out_stall | o_valid_res [0:0]
//
// One byte is taken per cycle while o_in_stall is low; a terminator's verdict
// passes the input register, which feeds the decode, then the result register,
// which holds the verdict.
// Non-terminator bytes never wait for the output side; a terminator waits in
// the input register only while a verdict is held by a stall.
// Reset (synchronous, active low) clears the decode state and both valids.
module utf8_strict_validator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [u8v_pkg::ByteW-1:0]   i_text_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_valid_res
);
    import u8v_pkg::*;

    logic             r_a_valid;
    logic [ByteW-1:0] r_a_byte;
    t_state           r_state;
    logic             r_out_valid;
    logic             r_res;

    t_state           n_state;
    t_verdict         dec_verdict;
    logic             out_free;
    logic             a_go;
    logic             a_free;
    logic             in_xfer;

    u8v_decode u_decode (
        .i_state   (r_state),
        .i_byte    (r_a_byte),
        .o_state   (n_state),
        .o_verdict (dec_verdict)
    );

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        a_go     = r_a_valid && ((r_a_byte != ByteTerm) || out_free);
        a_free   = !r_a_valid || a_go;
        in_xfer  = i_in_valid && a_free;
    end

    assign o_in_stall  = !a_free;
    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_state     <= StateClear;
            r_out_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_in_valid;
            end
            if (a_go) begin
                r_state <= n_state;
            end
            if (a_go && dec_verdict.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_byte <= i_text_byte;
        end
        if (a_go && dec_verdict.valid) begin
            r_res <= dec_verdict.res;
        end
    end

endmodule

@@ sv/u8v_checker.sv @@
module u8v_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_text_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_valid_res
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("verdict shown after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("verdict dropped while stalled");

    a_hold_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_valid_res))
        else $error("verdict changed while stalled");

    a_term_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_text_byte == 8'h00))
        ##1 (!o_out_valid || !i_out_stall) |=> o_out_valid)
        else $error("terminator transfer gave no verdict");

    a_byte_never_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

endmodule

bind utf8_strict_validator_core u8v_checker u_u8v_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_text_byte (i_text_byte),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_valid_res (o_valid_res)
);
